// ----- rtl/gg3_pkg.sv -----
// Shared types, register indexes and constants of the 3D grid gradient block.
package gg3_pkg;

    // Default values of the top-level parameters
    localparam int AXIS_POINTS_DEF   = 32;
    localparam int SAMPLE_WIDTH_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 16;

    // Fixed widths of the interface fields
    localparam int COORD_W   = 5;
    localparam int SIZE_W    = 6;
    localparam int STEP_W    = 32;
    localparam int VALUE_W   = 32;
    localparam int REG_IDX_W = 3;

    // Divider widths: magnitude and divisor are 33 bits, quotient is 32 bits
    localparam int MAG_W = 33;
    localparam int QUO_W = 32;
    localparam int CNT_W = 5;

    // Request codes
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [REG_IDX_W-1:0] REG_SIZE_I = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_J = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_SIZE_K = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_STEP_I = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_STEP_J = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STEP_K = 3'd5;

    // Register reset values
    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;
    localparam logic [STEP_W-1:0] STEP_RESET = 32'h0001_0000;

    // Saturation limits of a gradient
    localparam logic [VALUE_W-1:0] OUT_MAX = 32'h7FFF_FFFF;
    localparam logic [VALUE_W-1:0] OUT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic                      func;
        logic [COORD_W-1:0]        pos_i;
        logic [COORD_W-1:0]        pos_j;
        logic [COORD_W-1:0]        pos_k;
        logic signed [VALUE_W-1:0] sample_value;
    } gg3_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] grad_i;
        logic signed [VALUE_W-1:0] grad_j;
        logic signed [VALUE_W-1:0] grad_k;
        logic                      error;
    } gg3_result_t;

    typedef struct packed {
        logic             start;
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] divisor;
    } gg3_div_req_t;

    typedef struct packed {
        logic               done;
        logic [QUO_W-1:0]   quotient;
    } gg3_div_resp_t;

endpackage

// ----- rtl/gg3_grid_mem.sv -----
// Sample store: one write port, one read port, registered read data.
module gg3_grid_mem
    import gg3_pkg::*;
#(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32768
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/gg3_div.sv -----
// Saturating fixed-point divider: one restoring step per cycle.
module gg3_div
    import gg3_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  gg3_div_req_t  req,
    output gg3_div_resp_t resp
);

    localparam int NUM_W  = MAG_W + FRACTION_BITS;
    localparam int HEAD_W = NUM_W - QUO_W;
    localparam int CMP_W  = ((HEAD_W > MAG_W) ? HEAD_W : MAG_W) + 1;

    logic [NUM_W-1:0]  num_full;
    logic [HEAD_W-1:0] head;
    logic              overflow;

    logic              run_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [MAG_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  num_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [MAG_W-1:0]  dvs_reg;
    logic              neg_reg;
    logic              done_reg;
    logic [QUO_W-1:0]  res_reg;

    logic [MAG_W:0]    rem_shift;
    logic [MAG_W:0]    rem_sub;
    logic              fits;
    logic [MAG_W-1:0]  rem_next;
    logic [QUO_W-1:0]  quo_next;

    function automatic logic [QUO_W-1:0] saturate(input logic [QUO_W-1:0] q,
                                                  input logic neg);
        logic [QUO_W-1:0] r;
        if (neg)
        begin
            r = (q > OUT_MIN) ? OUT_MIN : (~q + 1'b1);
        end
        else
        begin
            r = q[QUO_W-1] ? OUT_MAX : q;
        end
        return r;
    endfunction

    // Numerator is mag * 2^F; its bits above the quotient width give the overflow test
    assign num_full = NUM_W'(req.mag) << FRACTION_BITS;
    assign head     = num_full[NUM_W-1:QUO_W];
    assign overflow = CMP_W'(head) >= CMP_W'(req.divisor);

    assign rem_shift = {rem_reg, num_reg[QUO_W-1]};
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};
    assign fits      = rem_shift >= {1'b0, dvs_reg};
    assign rem_next  = fits ? rem_sub[MAG_W-1:0] : rem_shift[MAG_W-1:0];
    assign quo_next  = {quo_reg[QUO_W-2:0], fits};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            cnt_reg  <= '0;
            rem_reg  <= '0;
            num_reg  <= '0;
            quo_reg  <= '0;
            dvs_reg  <= '0;
            neg_reg  <= 1'b0;
            done_reg <= 1'b0;
            res_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                neg_reg <= req.neg;
                dvs_reg <= req.divisor;
                if (req.mag == '0)
                begin
                    done_reg <= 1'b1;
                    res_reg  <= '0;
                end
                else if (overflow)
                begin
                    // covers a zero divisor as well
                    done_reg <= 1'b1;
                    res_reg  <= req.neg ? OUT_MIN : OUT_MAX;
                end
                else
                begin
                    run_reg <= 1'b1;
                    cnt_reg <= '0;
                    rem_reg <= MAG_W'(head);
                    num_reg <= num_full[QUO_W-1:0];
                    quo_reg <= '0;
                end
            end
            else if (run_reg)
            begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[QUO_W-2:0], 1'b0};
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                    res_reg  <= saturate(quo_next, neg_reg);
                end
            end
        end
    end

    assign resp.done     = done_reg;
    assign resp.quotient = res_reg;

endmodule

// ----- rtl/grid_gradient_3d.sv -----
// Top level of the 3D grid gradient block: config registers, query sequencer, store, divider.
//
//  Channel   Signals                          Direction  Transfer
//  request   start, busy, req                 in         start && !busy at a rising edge
//  result    done, result                     out        done high for one cycle, no stall
//  config    cfg_wen, cfg_addr, cfg_wdata     in         cfg_wen at a rising edge
//
// A write request within the store stores its sample at the accepting edge.
// A query request runs three axes in turn, each with two store reads and one pass
// through the shared divider (a load and then 32 restoring steps); an axis with a
// zero difference or a saturating quotient skips the steps. A query out of range
// strobes its error result in the cycle after its accept.
// Reset clears the sequencer and restores the register defaults; the store is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module grid_gradient_3d
    import gg3_pkg::*;
#(
    parameter int AXIS_POINTS   = AXIS_POINTS_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  gg3_req_t              req,
    output logic                  done,
    output gg3_result_t           result,
    input  logic                  cfg_wen,
    input  logic [REG_IDX_W-1:0]  cfg_addr,
    input  logic [STEP_W-1:0]     cfg_wdata
);

    // Store geometry; samples keep at most 32 bits
    localparam int GRID_DEPTH = AXIS_POINTS * AXIS_POINTS * AXIS_POINTS;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int SW         = (SAMPLE_WIDTH < VALUE_W) ? SAMPLE_WIDTH : VALUE_W;
    localparam int LIM_W      = 9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_HI,
        S_RD_LO,
        S_DIFF,
        S_DIV
    } state_t;

    typedef enum logic [1:0] {
        AX_I,
        AX_J,
        AX_K
    } axis_t;

    // Configuration registers
    logic [SIZE_W-1:0] size_i_reg;
    logic [SIZE_W-1:0] size_j_reg;
    logic [SIZE_W-1:0] size_k_reg;
    logic [STEP_W-1:0] step_i_reg;
    logic [STEP_W-1:0] step_j_reg;
    logic [STEP_W-1:0] step_k_reg;

    // Sequencer
    state_t             state_reg;
    axis_t              axis_reg;
    logic [COORD_W-1:0] ci_reg;
    logic [COORD_W-1:0] cj_reg;
    logic [COORD_W-1:0] ck_reg;
    logic [SW-1:0]      hi_reg;
    logic               done_reg;
    gg3_result_t        result_reg;

    logic [SIZE_W-1:0]  n_i;
    logic [SIZE_W-1:0]  n_j;
    logic [SIZE_W-1:0]  n_k;
    logic               query_bad;

    logic [COORD_W-1:0] p;
    logic [SIZE_W-1:0]  n;
    logic [STEP_W-1:0]  stp;
    logic               at_first;
    logic               at_last;
    logic [COORD_W-1:0] lo_p;
    logic [COORD_W-1:0] hi_p;
    logic [ADDR_W-1:0]  hi_addr;
    logic [ADDR_W-1:0]  lo_addr;

    // Store ports
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    logic [SW-1:0]      mem_rdata;

    // Divider
    logic signed [MAG_W-1:0] hi_ext;
    logic signed [MAG_W-1:0] lo_ext;
    logic signed [MAG_W-1:0] diff;
    gg3_div_req_t            div_req;
    gg3_div_resp_t           div_resp;

    function automatic logic [SIZE_W-1:0] used_size(input logic [SIZE_W-1:0] s);
        logic [SIZE_W-1:0] r;
        r = (LIM_W'(s) > LIM_W'(AXIS_POINTS)) ? SIZE_W'(AXIS_POINTS) : s;
        return r;
    endfunction

    function automatic logic [ADDR_W-1:0] grid_addr(input logic [COORD_W-1:0] i,
                                                    input logic [COORD_W-1:0] j,
                                                    input logic [COORD_W-1:0] k);
        logic [ADDR_W-1:0] a;
        a = ADDR_W'(i) * ADDR_W'(AXIS_POINTS * AXIS_POINTS)
          + ADDR_W'(j) * ADDR_W'(AXIS_POINTS)
          + ADDR_W'(k);
        return a;
    endfunction

    // Hold the configuration; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_i_reg <= SIZE_RESET;
            size_j_reg <= SIZE_RESET;
            size_k_reg <= SIZE_RESET;
            step_i_reg <= STEP_RESET;
            step_j_reg <= STEP_RESET;
            step_k_reg <= STEP_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_SIZE_I: size_i_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SIZE_J: size_j_reg <= cfg_wdata[SIZE_W-1:0];
                REG_SIZE_K: size_k_reg <= cfg_wdata[SIZE_W-1:0];
                REG_STEP_I: step_i_reg <= cfg_wdata;
                REG_STEP_J: step_j_reg <= cfg_wdata;
                REG_STEP_K: step_k_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // Sizes above AXIS_POINTS act as AXIS_POINTS
    assign n_i = used_size(size_i_reg);
    assign n_j = used_size(size_j_reg);
    assign n_k = used_size(size_k_reg);

    assign query_bad = (n_i < 6'd2) || (n_j < 6'd2) || (n_k < 6'd2)
                    || (SIZE_W'(req.pos_i) >= n_i)
                    || (SIZE_W'(req.pos_j) >= n_j)
                    || (SIZE_W'(req.pos_k) >= n_k);

    // Select the axis under work and pick the two neighbors of the point
    always_comb
    begin
        case (axis_reg)
            AX_I:
            begin
                p   = ci_reg;
                n   = n_i;
                stp = step_i_reg;
            end
            AX_J:
            begin
                p   = cj_reg;
                n   = n_j;
                stp = step_j_reg;
            end
            default:
            begin
                p   = ck_reg;
                n   = n_k;
                stp = step_k_reg;
            end
        endcase
    end

    assign at_first = (p == '0);
    assign at_last  = (SIZE_W'(p) == n - 6'd1);
    // first index: forward difference; last index: backward; else central
    assign lo_p     = at_first ? p : p - 1'b1;
    assign hi_p     = (!at_first && at_last) ? p : p + 1'b1;

    assign hi_addr = grid_addr((axis_reg == AX_I) ? hi_p : ci_reg,
                               (axis_reg == AX_J) ? hi_p : cj_reg,
                               (axis_reg == AX_K) ? hi_p : ck_reg);
    assign lo_addr = grid_addr((axis_reg == AX_I) ? lo_p : ci_reg,
                               (axis_reg == AX_J) ? lo_p : cj_reg,
                               (axis_reg == AX_K) ? lo_p : ck_reg);

    // Store a write request at once; drop coordinates beyond the store
    assign mem_we    = start && !busy && (req.func == FUNC_WRITE)
                    && (LIM_W'(req.pos_i) < LIM_W'(AXIS_POINTS))
                    && (LIM_W'(req.pos_j) < LIM_W'(AXIS_POINTS))
                    && (LIM_W'(req.pos_k) < LIM_W'(AXIS_POINTS));
    assign mem_waddr = grid_addr(req.pos_i, req.pos_j, req.pos_k);
    assign mem_raddr = (state_reg == S_RD_HI) ? hi_addr : lo_addr;

    gg3_grid_mem #(
        .ADDR_W (ADDR_W),
        .DATA_W (SW),
        .DEPTH  (GRID_DEPTH)
    ) u_grid_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (req.sample_value[SW-1:0]),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Difference of the two neighbors; the low one arrives in the divider load cycle
    assign hi_ext = MAG_W'($signed(hi_reg));
    assign lo_ext = MAG_W'($signed(mem_rdata));
    assign diff   = hi_ext - lo_ext;

    assign div_req.start   = (state_reg == S_DIFF);
    assign div_req.neg     = diff[MAG_W-1];
    assign div_req.mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    assign div_req.divisor = (!at_first && !at_last) ? {stp, 1'b0} : {1'b0, stp};

    gg3_div #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .resp  (div_resp)
    );

    // Query sequencer and the registered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            axis_reg   <= AX_I;
            ci_reg     <= '0;
            cj_reg     <= '0;
            ck_reg     <= '0;
            hi_reg     <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start && (req.func == FUNC_QUERY))
                    begin
                        ci_reg   <= req.pos_i;
                        cj_reg   <= req.pos_j;
                        ck_reg   <= req.pos_k;
                        axis_reg <= AX_I;
                        if (query_bad)
                        begin
                            result_reg <= '{grad_i: '0, grad_j: '0, grad_k: '0, error: 1'b1};
                            done_reg   <= 1'b1;
                        end
                        else
                        begin
                            state_reg <= S_RD_HI;
                        end
                    end
                end
                S_RD_HI:
                begin
                    state_reg <= S_RD_LO;
                end
                S_RD_LO:
                begin
                    hi_reg    <= mem_rdata;
                    state_reg <= S_DIFF;
                end
                S_DIFF:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (div_resp.done)
                    begin
                        case (axis_reg)
                            AX_I:
                            begin
                                result_reg.grad_i <= div_resp.quotient;
                                axis_reg          <= AX_J;
                                state_reg         <= S_RD_HI;
                            end
                            AX_J:
                            begin
                                result_reg.grad_j <= div_resp.quotient;
                                axis_reg          <= AX_K;
                                state_reg         <= S_RD_HI;
                            end
                            default:
                            begin
                                result_reg.grad_k <= div_resp.quotient;
                                result_reg.error  <= 1'b0;
                                done_reg          <= 1'b1;
                                state_reg         <= S_IDLE;
                            end
                        endcase
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // A result leaves only once the sequencer is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // The store is never written in the middle of a query
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> !busy)
        else $error("store write during a query");

    // The divider answers only while the sequencer waits for it
    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_resp.done |-> (state_reg == S_DIV))
        else $error("divider result outside its wait state");

    // An out-of-range query returns zero gradients
    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.error) |->
            (result.grad_i == '0 && result.grad_j == '0 && result.grad_k == '0))
        else $error("error result with nonzero gradient");

endmodule
